// File: design/rarc_pkg.sv
// Shared types and constants of the RADIUS attribute rule classifier.
// Depends on nothing; rarc_front, rarc_back and the top level import it.
package rarc_pkg;

  localparam int MAX_RULES = 16;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int LIM_W     = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
  localparam int RULE_W    = 52;

  localparam logic [7:0] MIN_LEN_VENDOR  = 8'd8;
  localparam logic [7:0] MIN_LEN_SUBTYPE = 8'd10;

  localparam logic [1:0] ACTION_DROP = 2'd1;
  localparam logic [1:0] ACTION_ECHO = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_KEEP = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_ECHO = 2'd2
  } verdict_t;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    OC_SKIP,
    OC_STOP,
    OC_DECIDE
  } outcome_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] vendor;
    logic [7:0]  subtype;
    logic        is_vendor;
    logic        is_subtyped;
    logic [1:0]  action;
  } rule_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  length;
    logic [31:0] vendor;
    logic [7:0]  subtype;
  } attr_t;

  typedef struct packed {
    func_t      func;
    logic [3:0] rule_index;
    rule_t      rule;
    attr_t      attr;
  } q_item_t;

  function automatic verdict_t verdict_of(logic [1:0] action);
    verdict_t v;
    unique case (action)
      ACTION_DROP: v = VERDICT_DROP;
      ACTION_ECHO: v = VERDICT_ECHO;
      default:     v = VERDICT_KEEP;
    endcase
    return v;
  endfunction

endpackage

// File: design/rarc_if.sv
// Valid/ready channel interfaces of the classifier: input items and verdicts.
// Depends on nothing.
interface rarc_in_if ();
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  rule_index;
  logic [7:0]  rule_code;
  logic [31:0] rule_vendor;
  logic [7:0]  rule_subtype;
  logic        rule_is_vendor;
  logic        rule_is_subtyped;
  logic [1:0]  rule_action;
  logic [7:0]  attr_code;
  logic [7:0]  attr_length;
  logic [31:0] attr_vendor;
  logic [7:0]  attr_vendor_subtype;

  modport source (
    output valid, func, rule_index, rule_code, rule_vendor, rule_subtype,
           rule_is_vendor, rule_is_subtyped, rule_action, attr_code,
           attr_length, attr_vendor, attr_vendor_subtype,
    input  ready
  );
  modport sink (
    input  valid, func, rule_index, rule_code, rule_vendor, rule_subtype,
           rule_is_vendor, rule_is_subtyped, rule_action, attr_code,
           attr_length, attr_vendor, attr_vendor_subtype,
    output ready
  );
endinterface

interface rarc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// File: design/rarc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rarc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/rarc_front.sv
// Front end: accepts input beats and holds them in a two-entry queue.
// Depends on rarc_pkg and rarc_in_if.
module rarc_front import rarc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rarc_in_if.sink   in_ch,
  output logic      q_valid,
  output q_item_t   q_item,
  input  logic      q_pop
);

  q_item_t    q_mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  q_item_t    in_item;

  always_comb begin
    in_item.func             = func_t'(in_ch.func);
    in_item.rule_index       = in_ch.rule_index;
    in_item.rule.code        = in_ch.rule_code;
    in_item.rule.vendor      = in_ch.rule_vendor;
    in_item.rule.subtype     = in_ch.rule_subtype;
    in_item.rule.is_vendor   = in_ch.rule_is_vendor;
    in_item.rule.is_subtyped = in_ch.rule_is_subtyped;
    in_item.rule.action      = in_ch.rule_action;
    in_item.attr.code        = in_ch.attr_code;
    in_item.attr.length      = in_ch.attr_length;
    in_item.attr.vendor      = in_ch.attr_vendor;
    in_item.attr.subtype     = in_ch.attr_vendor_subtype;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (cnt_r != 2'd0);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= in_item;
    end
  end

endmodule

// File: design/rarc_back.sv
// Back end: writes rules into the table and walks it for classify beats.
// Depends on rarc_pkg, rarc_out_if and rarc_ram.
module rarc_back import rarc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       q_valid,
  input  q_item_t    q_item,
  output logic       q_pop,
  rarc_out_if.source out_ch
);

  back_state_t      state_r, state_nxt;
  logic [4:0]       rule_count_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  attr_t            attr_r, attr_nxt;
  verdict_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r, verdict_nxt;

  logic [LIM_W-1:0]  lim;
  logic              last;
  logic              out_free;
  logic              is_load;
  logic              load_ok;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RULE_W-1:0] ram_rdata;
  rule_t             rule;
  outcome_t          outcome;

  rarc_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(q_item.rule_index)),
    .wdata (q_item.rule),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rule     = rule_t'(ram_rdata);
  assign lim      = (LIM_W'(rule_count_r) > LIM_W'(MAX_RULES)) ? LIM_W'(MAX_RULES)
                                                               : LIM_W'(rule_count_r);
  assign last     = (LIM_W'(idx_r) + LIM_W'(1)) == lim;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_load  = (q_item.func == FUNC_LOAD);
  assign load_ok  = LIM_W'(q_item.rule_index) < LIM_W'(MAX_RULES);

  always_comb begin
    if (rule.code < attr_r.code) begin
      outcome = OC_SKIP;
    end else if (rule.code > attr_r.code) begin
      outcome = OC_STOP;
    end else if (!rule.is_vendor) begin
      outcome = OC_DECIDE;
    end else if (attr_r.length < MIN_LEN_VENDOR) begin
      outcome = OC_SKIP;
    end else if (rule.vendor < attr_r.vendor) begin
      outcome = OC_SKIP;
    end else if (rule.vendor > attr_r.vendor) begin
      outcome = OC_STOP;
    end else if (!rule.is_subtyped) begin
      outcome = OC_DECIDE;
    end else if (attr_r.length < MIN_LEN_SUBTYPE) begin
      outcome = OC_SKIP;
    end else if (rule.subtype == attr_r.subtype) begin
      outcome = OC_DECIDE;
    end else begin
      outcome = OC_SKIP;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && !is_load) begin
          state_nxt = (lim == '0) ? BK_EMIT : BK_WALK;
        end
      end
      BK_WALK: begin
        if (outcome != OC_SKIP || last) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = idx_r + IDX_W'(1);
    idx_nxt       = idx_r;
    attr_nxt      = attr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    verdict_nxt   = verdict_r;
    unique case (state_r)
      BK_IDLE: begin
        ram_raddr = '0;
        if (q_valid) begin
          q_pop  = 1'b1;
          ram_we = is_load && load_ok;
          if (!is_load) begin
            idx_nxt  = '0;
            attr_nxt = q_item.attr;
            res_nxt  = VERDICT_KEEP;
          end
        end
      end
      BK_WALK: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (outcome == OC_DECIDE) begin
          res_nxt = verdict_of(rule.action);
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          verdict_nxt   = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      rule_count_r <= 5'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rule_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    attr_r    <= attr_nxt;
    res_r     <= res_nxt;
    verdict_r <= verdict_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = verdict_r;

endmodule

// File: design/radius_attribute_rule_classifier.sv
// Top level of the RADIUS attribute rule classifier: front queue and rule walker.
// Depends on rarc_pkg, rarc_if, rarc_front and rarc_back.
//
//   Channel  Direction  Beat contents
//   in_ch    input      func, rule fields of a load, attribute fields of a classify
//   out_ch   output     verdict, one per classify beat
//   cfg_*    input      rule_count write, taken whenever cfg_we is high
//
// A load beat is written to the table from the idle state. A classify beat
// walks n rules (at most min(rule_count, 16)): idle issues the first table
// read, walk reads one rule per step, emit posts the verdict once the output
// register is free. Inputs queue two deep ahead of the walker, and a verdict
// waits in the output register while the walker keeps taking load beats.
// Reset clears control state only; the rule table holds nothing until loaded.
module radius_attribute_rule_classifier import rarc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rarc_in_if.sink    in_ch,
  rarc_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  rarc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rarc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: design/rarc_checker.sv
// Port-level checks of the classifier's verdict channel, bound to the top level.
// Depends on radius_attribute_rule_classifier.
module rarc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict
);

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != 2'd3)
    else $error("verdict beat carries an unused code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict beat changed or vanished");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict beat offered right after reset");

endmodule

bind radius_attribute_rule_classifier rarc_checker u_rarc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_verdict (out_ch.verdict)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the RADIUS attribute rule classifier: queued load and classify beats,
// a clocked driver and monitor, and an in-bench rule walk that predicts every verdict.
// Depends on rarc_pkg, the rarc_in_if and rarc_out_if interfaces and the classifier top level.
module tb_top;
  import rarc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  rarc_in_if  in_ch ();
  rarc_out_if out_ch ();

  radius_attribute_rule_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  q_item_t  beat_q[$];
  verdict_t verdict_q[$];
  q_item_t  on_bus;
  verdict_t want_verdict;

  rule_t loaded_rules[MAX_RULES];
  rule_t steer_rules[MAX_RULES];
  int    walk_count;
  int    beats_queued;
  int    mismatches;
  int    src_idle_pct;
  int    snk_idle_pct;
  int    hold_left;
  logic  hold_arm;
  logic  hold_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #3_000_000;
    $display("radius_attribute_rule_classifier: mismatch");
    $finish;
  end

  function automatic verdict_t classify_attr(attr_t a);
    rule_t r;
    int    n;
    n = (walk_count > MAX_RULES) ? MAX_RULES : walk_count;
    for (int i = 0; i < n; i++) begin
      r = loaded_rules[i];
      if (r.code < a.code) continue;
      if (r.code > a.code) break;
      if (r.is_vendor) begin
        if (a.length < MIN_LEN_VENDOR) continue;
        if (r.vendor < a.vendor) continue;
        if (r.vendor > a.vendor) break;
        if (r.is_subtyped) begin
          if (a.length < MIN_LEN_SUBTYPE) continue;
          if (r.subtype != a.subtype) continue;
        end
      end
      case (r.action)
        ACTION_DROP: return VERDICT_DROP;
        ACTION_ECHO: return VERDICT_ECHO;
        default:     return VERDICT_KEEP;
      endcase
    end
    return VERDICT_KEEP;
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    r.code        = 8'($urandom);
    r.vendor      = $urandom;
    r.subtype     = 8'($urandom);
    r.is_vendor   = 1'($urandom);
    r.is_subtyped = 1'($urandom);
    r.action      = 2'($urandom);
    return r;
  endfunction

  function automatic attr_t random_attr();
    attr_t a;
    a.code    = 8'($urandom);
    a.length  = 8'($urandom);
    a.vendor  = $urandom;
    a.subtype = 8'($urandom);
    return a;
  endfunction

  function automatic rule_t mk_rule(logic [7:0] code, logic [31:0] vendor, logic [7:0] sub,
                                    logic isv, logic iss, logic [1:0] action);
    rule_t r;
    r.code        = code;
    r.vendor      = vendor;
    r.subtype     = sub;
    r.is_vendor   = isv;
    r.is_subtyped = iss;
    r.action      = action;
    return r;
  endfunction

  task automatic push_load(int idx, rule_t r);
    q_item_t b;
    b.func       = FUNC_LOAD;
    b.rule_index = 4'(idx);
    b.rule       = r;
    b.attr       = random_attr();
    steer_rules[idx] = r;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  task automatic push_classify(logic [7:0] code, logic [7:0] len, logic [31:0] vendor,
                               logic [7:0] sub);
    q_item_t b;
    b.func         = FUNC_CLASSIFY;
    b.rule_index   = 4'($urandom);
    b.rule         = random_rule();
    b.attr.code    = code;
    b.attr.length  = len;
    b.attr.vendor  = vendor;
    b.attr.subtype = sub;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // A well-formed table is ascending by code and, within one code, by vendor id.
  task automatic queue_rule_table(bit sorted);
    rule_t       r;
    logic [7:0]  code;
    logic [31:0] vend;
    code = 8'($urandom_range(0, 180));
    vend = $urandom >> $urandom_range(0, 31);
    for (int i = 0; i < MAX_RULES; i++) begin
      r = random_rule();
      if (sorted) begin
        if ($urandom_range(99) < 35 && code < 8'd235) begin
          code = code + 8'($urandom_range(1, 20));
          vend = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom >> $urandom_range(0, 31);
        end else if (vend <= 32'hFFFF_FFF0) begin
          vend = vend + 32'($urandom_range(0, 3));
        end
        r.code   = code;
        r.vendor = vend;
        r.action = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
      end
      push_load(i, r);
    end
  endtask

  task automatic queue_attr();
    rule_t       r;
    logic [7:0]  code;
    logic [7:0]  len;
    logic [31:0] vend;
    int          lim;
    lim  = (walk_count > MAX_RULES) ? MAX_RULES : ((walk_count == 0) ? 1 : walk_count);
    r    = steer_rules[$urandom_range(lim - 1)];
    code = ($urandom_range(9) < 8) ? r.code : 8'($urandom);
    len  = ($urandom_range(9) < 8) ? 8'($urandom_range(6, 11)) : 8'($urandom);
    case ($urandom_range(9))
      6:       vend = r.vendor + 32'd1;
      7:       vend = r.vendor - 32'd1;
      8, 9:    vend = $urandom;
      default: vend = r.vendor;
    endcase
    push_classify(code, len, vend, ($urandom_range(9) < 7) ? r.subtype : 8'($urandom));
  endtask

  task automatic write_rule_count(logic [4:0] value);
    while (beat_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    walk_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (on_bus.func == FUNC_LOAD) begin
          loaded_rules[on_bus.rule_index] = on_bus.rule;
        end else begin
          verdict_q.push_back(classify_attr(on_bus.attr));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus = beat_q.pop_front();
          in_ch.valid               <= 1'b1;
          in_ch.func                <= on_bus.func;
          in_ch.rule_index          <= on_bus.rule_index;
          in_ch.rule_code           <= on_bus.rule.code;
          in_ch.rule_vendor         <= on_bus.rule.vendor;
          in_ch.rule_subtype        <= on_bus.rule.subtype;
          in_ch.rule_is_vendor      <= on_bus.rule.is_vendor;
          in_ch.rule_is_subtyped    <= on_bus.rule.is_subtyped;
          in_ch.rule_action         <= on_bus.rule.action;
          in_ch.attr_code           <= on_bus.attr.code;
          in_ch.attr_length         <= on_bus.attr.length;
          in_ch.attr_vendor         <= on_bus.attr.vendor;
          in_ch.attr_vendor_subtype <= on_bus.attr.subtype;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict: expected none, got %0d", out_ch.verdict);
          mismatches++;
        end else begin
          want_verdict = verdict_q.pop_front();
          if (out_ch.verdict !== want_verdict) begin
            $error("verdict: expected %0d, got %0d", want_verdict, out_ch.verdict);
            mismatches++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    int seg_counts[12];
    int roll;
    int seg_end;
    seg_counts = '{16, 31, 1, 0, 17, 8, 16, 2, 31, 15, 16, 5};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_LOAD;
    in_ch.rule_index = '0;
    in_ch.rule_code = '0;
    in_ch.rule_vendor = '0;
    in_ch.rule_subtype = '0;
    in_ch.rule_is_vendor = 1'b0;
    in_ch.rule_is_subtyped = 1'b0;
    in_ch.rule_action = '0;
    in_ch.attr_code = '0;
    in_ch.attr_length = '0;
    in_ch.attr_vendor = '0;
    in_ch.attr_vendor_subtype = '0;
    out_ch.ready = 1'b0;
    walk_count   = 0;
    beats_queued = 0;
    mismatches   = 0;
    src_idle_pct = 11;
    snk_idle_pct = 75;
    hold_arm     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // With no rules walked every attribute is kept.
    push_classify(8'd26, 8'd255, 32'hFFFF_FFFF, 8'hFF);
    push_classify(8'd0, 8'd0, 32'd0, 8'd0);
    push_load(0, mk_rule(8'd0, 32'd0, 8'd0, 1'b0, 1'b0, 2'd3));
    push_load(1, mk_rule(8'd5, 32'd0, 8'd0, 1'b0, 1'b0, ACTION_DROP));
    push_load(2, mk_rule(8'd26, 32'd9, 8'd0, 1'b1, 1'b0, ACTION_ECHO));
    push_load(3, mk_rule(8'd26, 32'd100, 8'd7, 1'b1, 1'b1, ACTION_DROP));
    push_load(4, mk_rule(8'd26, 32'd100, 8'd8, 1'b1, 1'b1, ACTION_ECHO));
    push_load(5, mk_rule(8'd26, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0, 2'd0));
    for (int i = 6; i < 15; i++) begin
      push_load(i, mk_rule(8'(100 + i), 32'd0, 8'd0, 1'b0, 1'b0,
                           (i % 2) ? ACTION_DROP : ACTION_ECHO));
    end
    push_load(15, mk_rule(8'd255, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, ACTION_ECHO));
    write_rule_count(5'd16);
    push_classify(8'd0, 8'd2, 32'd0, 8'd0);
    push_classify(8'd5, 8'd2, 32'd0, 8'd0);
    push_classify(8'd3, 8'd2, 32'd0, 8'd0);
    push_classify(8'd26, 8'd7, 32'd9, 8'd0);
    push_classify(8'd26, 8'd8, 32'd9, 8'd0);
    push_classify(8'd26, 8'd9, 32'd100, 8'd7);
    push_classify(8'd26, 8'd10, 32'd100, 8'd8);
    push_classify(8'd26, 8'd255, 32'd50, 8'd0);
    push_classify(8'd255, 8'd255, 32'hFFFF_FFFF, 8'hFF);

    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 5 || seg == 10) seg_counts[seg] = $urandom_range(0, 31);
      write_rule_count(5'(seg_counts[seg]));
      if (seg >= 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (seg >= 4) begin
        src_idle_pct = 75;
        snk_idle_pct = 11;
      end
      if (seg == 9) hold_arm = 1'b1;
      seg_end = beats_queued + 140;
      while (beats_queued < seg_end) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          queue_rule_table(1'b1);
        end else if (roll < 4) begin
          queue_rule_table(1'b0);
        end else if (roll < 8) begin
          push_load($urandom_range(MAX_RULES - 1), random_rule());
        end else if (roll < 11) begin
          push_classify(8'($urandom), 8'($urandom), $urandom, 8'($urandom));
        end else begin
          queue_attr();
        end
      end
    end

    while (beat_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("radius_attribute_rule_classifier: match");
    end else begin
      $display("radius_attribute_rule_classifier: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/rarc_pkg.sv
design/rarc_if.sv
design/rarc_ram.sv
design/rarc_front.sv
design/rarc_back.sv
design/radius_attribute_rule_classifier.sv
design/rarc_checker.sv
dv/tb_top.sv
